### rtl/ckm_pkg.sv
package ckm_pkg;

    localparam int BUFFER_SIZE = 32;
    localparam int TAKEN_W     = $clog2(BUFFER_SIZE);
    localparam logic [TAKEN_W-1:0] TAKEN_LIMIT = TAKEN_W'(BUFFER_SIZE - 1);

    localparam int CH_W        = 8;
    localparam int CODE_W      = 3;
    localparam int NUM_KEYS    = 13;
    localparam int KEY_MAX_LEN = 8;
    localparam int POS_W       = 4;
    localparam logic [POS_W-1:0] POS_MAX = '1;

    typedef logic [CH_W-1:0]     ch_t;
    typedef logic [NUM_KEYS-1:0] key_mask_t;
    typedef logic [POS_W-1:0]    pos_t;

    typedef enum logic [CODE_W-1:0] {
        CMD_STOP    = 3'd0,
        CMD_FORWARD = 3'd1,
        CMD_BACK    = 3'd2,
        CMD_LEFT    = 3'd3,
        CMD_RIGHT   = 3'd4,
        CMD_STATUS  = 3'd5,
        CMD_PING    = 3'd6,
        CMD_UNKNOWN = 3'd7
    } cmd_t;

    localparam ch_t CH_NUL     = 8'h00;
    localparam ch_t CH_TAB     = 8'h09;
    localparam ch_t CH_CR      = 8'h0D;
    localparam ch_t CH_SPACE   = 8'h20;
    localparam ch_t CH_LOWER_A = 8'h61;
    localparam ch_t CH_LOWER_Z = 8'h7A;
    localparam ch_t CASE_DIFF  = 8'h20;

    // keyword letters, padded with nul past the end of each keyword
    localparam ch_t KEY_TEXT [NUM_KEYS][KEY_MAX_LEN] = '{
        '{"S", "T", "O", "P", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"F", "O", "R", "W", "A", "R", "D", CH_NUL},
        '{"F", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"B", "A", "C", "K", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"B", "A", "C", "K", "W", "A", "R", "D"},
        '{"B", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"L", "E", "F", "T", CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"L", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"R", "I", "G", "H", "T", CH_NUL, CH_NUL, CH_NUL},
        '{"R", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"S", "T", "A", "T", "U", "S", CH_NUL, CH_NUL},
        '{"S", CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL, CH_NUL},
        '{"P", "I", "N", "G", CH_NUL, CH_NUL, CH_NUL, CH_NUL}
    };

    localparam pos_t KEY_LEN [NUM_KEYS] = '{
        4'd4, 4'd7, 4'd1, 4'd4, 4'd8, 4'd1, 4'd4, 4'd1, 4'd5, 4'd1, 4'd6, 4'd1, 4'd4
    };

    localparam cmd_t KEY_CODE [NUM_KEYS] = '{
        CMD_STOP, CMD_FORWARD, CMD_FORWARD, CMD_BACK, CMD_BACK, CMD_BACK,
        CMD_LEFT, CMD_LEFT, CMD_RIGHT, CMD_RIGHT, CMD_STATUS, CMD_STATUS, CMD_PING
    };

    function automatic ch_t key_char(input int k, input pos_t pos);
        ch_t c;
        c = CH_NUL;
        if (!pos[POS_W-1]) begin
            c = KEY_TEXT[k][pos[POS_W-2:0]];
        end
        return c;
    endfunction

endpackage

### rtl/command_keyword_matcher.sv
// Command keyword matcher: takes one character byte per item on the s_ side and, when a
// zero byte ends the line, gives one command code on the m_ side (0 stop, 1 forward,
// 2 back, 3 left, 4 right, 5 status, 6 ping, 7 unknown). Only the first BUFFER_SIZE-1
// bytes of a line count; leading and trailing space, tab and CR are trimmed and letters
// are case folded before an exact keyword compare. An input register feeds the per-byte
// match update and the code decode, which loads the result register, so a new byte is
// taken each cycle while the result side keeps up; a zero byte waits in the input
// register only while an earlier code is still unread. Match state returns to reset
// after every line.
module command_keyword_matcher (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // ch
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata     // command_code, zero filled above bit 2
);

    logic          item_valid;
    ckm_pkg::ch_t  item_ch;
    logic          advance;
    logic          out_free;
    logic          line_end;
    ckm_pkg::cmd_t code;

    assign line_end = item_ch == ckm_pkg::CH_NUL;
    assign advance  = item_valid && (!line_end || out_free);

    ckm_in_stage u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .advance    (advance),
        .item_valid (item_valid),
        .item_ch    (item_ch)
    );

    ckm_match u_match (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .ch      (item_ch),
        .code    (code)
    );

    ckm_out_stage u_out (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .load     (advance && line_end),
        .code     (code),
        .out_free (out_free),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule

### rtl/ckm_in_stage.sv
module ckm_in_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // ch
    input  logic              advance,
    output logic              item_valid,
    output ckm_pkg::ch_t      item_ch
);

    logic         valid_reg;
    logic         valid_next;
    ckm_pkg::ch_t ch_reg;

    assign s_tready   = aresetn && (!valid_reg || advance);
    assign valid_next = s_tready ? s_tvalid : valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            ch_reg <= s_tdata;
        end
    end

    assign item_valid = valid_reg;
    assign item_ch    = ch_reg;

endmodule

### rtl/ckm_match.sv
module ckm_match (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           step,
    input  ckm_pkg::ch_t   ch,
    output ckm_pkg::cmd_t  code
);

    logic                           in_leading_reg, in_leading_next;
    logic                           trailing_reg, trailing_next;
    logic [ckm_pkg::TAKEN_W-1:0]    taken_reg, taken_next;
    ckm_pkg::key_mask_t             alive_reg, alive_next;
    ckm_pkg::pos_t                  pos_reg, pos_next;
    ckm_pkg::ch_t                   upper_ch;
    logic                           blank;

    always_comb begin
        blank    = ch inside {ckm_pkg::CH_SPACE, ckm_pkg::CH_TAB, ckm_pkg::CH_CR};
        upper_ch = ch;
        if (ch inside {[ckm_pkg::CH_LOWER_A:ckm_pkg::CH_LOWER_Z]}) begin
            upper_ch = ch - ckm_pkg::CASE_DIFF;
        end
    end

    // first surviving keyword whose length equals the matched count
    always_comb begin
        code = ckm_pkg::CMD_UNKNOWN;
        for (int k = ckm_pkg::NUM_KEYS - 1; k >= 0; k--) begin
            if (alive_reg[k] && ckm_pkg::KEY_LEN[k] == pos_reg) begin
                code = ckm_pkg::KEY_CODE[k];
            end
        end
    end

    always_comb begin
        in_leading_next = in_leading_reg;
        trailing_next   = trailing_reg;
        taken_next      = taken_reg;
        alive_next      = alive_reg;
        pos_next        = pos_reg;
        if (ch == ckm_pkg::CH_NUL) begin
            in_leading_next = 1'b1;
            trailing_next   = 1'b0;
            taken_next      = '0;
            alive_next      = '1;
            pos_next        = '0;
        end else if (taken_reg != ckm_pkg::TAKEN_LIMIT) begin
            taken_next = taken_reg + 1'b1;
            if (blank) begin
                if (!in_leading_reg) begin
                    trailing_next = 1'b1;
                end
            end else begin
                in_leading_next = 1'b0;
                for (int k = 0; k < ckm_pkg::NUM_KEYS; k++) begin
                    alive_next[k] = alive_reg[k] && !trailing_reg
                                    && ckm_pkg::key_char(k, pos_reg) == upper_ch;
                end
                if (pos_reg != ckm_pkg::POS_MAX) begin
                    pos_next = pos_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_leading_reg <= 1'b1;
            trailing_reg   <= 1'b0;
            taken_reg      <= '0;
            alive_reg      <= '1;
            pos_reg        <= '0;
        end else if (step) begin
            in_leading_reg <= in_leading_next;
            trailing_reg   <= trailing_next;
            taken_reg      <= taken_next;
            alive_reg      <= alive_next;
            pos_reg        <= pos_next;
        end
    end

endmodule

### rtl/ckm_out_stage.sv
module ckm_out_stage (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           load,
    input  ckm_pkg::cmd_t  code,
    output logic           out_free,
    output logic           m_tvalid,
    input  logic           m_tready,
    output logic [7:0]     m_tdata    // command_code
);

    logic          valid_reg;
    logic          valid_next;
    ckm_pkg::cmd_t code_reg;

    assign out_free   = !valid_reg || m_tready;
    assign valid_next = load || (valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            code_reg <= code;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {5'd0, code_reg};

endmodule
